@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: condition broken");

// Consequent holds at every edge where the antecedent holds.
`define ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication broken");

`endif

@@ rtl/core/rti_pkg.sv @@
// Shared widths, types and constants for the ray/triangle intersection block.
// No dependencies.
package rti_pkg;

    localparam int COORD_WIDTH     = 20;
    localparam int DIST_WIDTH      = 32;
    localparam int DIST_FRAC       = DIST_WIDTH / 2;
    localparam int NUM_VERTEX      = 3;
    localparam int NUM_CROSS       = NUM_VERTEX + 1;
    localparam int NUM_DOT         = NUM_VERTEX + 2;
    localparam int CFG_WIDTH       = 3 * COORD_WIDTH;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int DIFF_WIDTH      = COORD_WIDTH + 1;
    localparam int PROD_WIDTH      = 2 * DIFF_WIDTH;
    localparam int CROSS_WIDTH     = PROD_WIDTH + 1;
    localparam int DOTP_WIDTH      = CROSS_WIDTH + DIFF_WIDTH;
    localparam int SUM_WIDTH       = DOTP_WIDTH + 2;
    localparam int REM_WIDTH       = SUM_WIDTH + 1;
    // six front stages, one divider stage per quotient bit, one output register
    localparam int LATENCY         = 7 + DIST_WIDTH;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_VERTEX_A = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_VERTEX_B = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_VERTEX_C = 2'd2;

    // cyclic axis / vertex successor and predecessor
    localparam int NEXT_IDX [3] = '{1, 2, 0};
    localparam int PREV_IDX [3] = '{2, 0, 1};

    // dot product slots
    localparam int DOT_NV   = 0;
    localparam int DOT_XP   = 1;
    localparam int DOT_EDGE = 2;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [CROSS_WIDTH-1:0] cross_t;
    typedef logic signed [DOTP_WIDTH-1:0]  dotp_t;
    typedef logic signed [SUM_WIDTH-1:0]   sum_t;

    typedef struct packed {
        logic valid;
        logic pass;
        logic sat;
    } div_ctrl_t;

endpackage

@@ rtl/core/rti_div.sv @@
// Pipelined restoring divider: one quotient bit per stage.
// Depends on rti_pkg.
module rti_div
    import rti_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  div_ctrl_t            ctrl_in,
    input  logic [SUM_WIDTH-1:0] den_in,
    input  logic [REM_WIDTH-1:0] rem_in,
    input  logic [DIST_WIDTH-1:0] num_in,
    output div_ctrl_t            ctrl_out,
    output logic [DIST_WIDTH-1:0] quot_out
);

    div_ctrl_t             ctrl_reg [DIST_WIDTH];
    logic [SUM_WIDTH-1:0]  den_reg  [DIST_WIDTH];
    logic [REM_WIDTH-1:0]  rem_reg  [DIST_WIDTH];
    logic [DIST_WIDTH-1:0] num_reg  [DIST_WIDTH];
    logic [DIST_WIDTH-1:0] quot_reg [DIST_WIDTH];

    div_ctrl_t             ctrl_src [DIST_WIDTH];
    logic [SUM_WIDTH-1:0]  den_src  [DIST_WIDTH];
    logic [REM_WIDTH-1:0]  rem_src  [DIST_WIDTH];
    logic [DIST_WIDTH-1:0] num_src  [DIST_WIDTH];
    logic [DIST_WIDTH-1:0] quot_src [DIST_WIDTH];

    logic [REM_WIDTH-1:0]  rem_next  [DIST_WIDTH];
    logic [DIST_WIDTH-1:0] quot_next [DIST_WIDTH];

    for (genvar s = 0; s < DIST_WIDTH; s++) begin : g_stage
        logic [REM_WIDTH-1:0] shifted;
        logic                 ge;

        if (s == 0) begin : g_first
            assign ctrl_src[s] = ctrl_in;
            assign den_src[s]  = den_in;
            assign rem_src[s]  = rem_in;
            assign num_src[s]  = num_in;
            assign quot_src[s] = '0;
        end
        else begin : g_rest
            assign ctrl_src[s] = ctrl_reg[s-1];
            assign den_src[s]  = den_reg[s-1];
            assign rem_src[s]  = rem_reg[s-1];
            assign num_src[s]  = num_reg[s-1];
            assign quot_src[s] = quot_reg[s-1];
        end

        // bring down the next numerator bit, subtract where it fits
        assign shifted      = {rem_src[s][REM_WIDTH-2:0], num_src[s][DIST_WIDTH-1]};
        assign ge           = shifted >= {1'b0, den_src[s]};
        assign rem_next[s]  = ge ? shifted - {1'b0, den_src[s]} : shifted;
        assign quot_next[s] = {quot_src[s][DIST_WIDTH-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctrl_reg[s] <= '0;
            end
            else
            begin
                ctrl_reg[s] <= ctrl_src[s];
            end
        end

        always_ff @(posedge clk)
        begin
            den_reg[s]  <= den_src[s];
            rem_reg[s]  <= rem_next[s];
            num_reg[s]  <= num_src[s] << 1;
            quot_reg[s] <= quot_next[s];
        end
    end

    assign ctrl_out = ctrl_reg[DIST_WIDTH-1];
    assign quot_out = quot_reg[DIST_WIDTH-1];

endmodule

@@ rtl/core/ray_triangle_intersect.sv @@
// Ray/triangle intersection top level: front-end pipeline, divider and output register.
// Depends on rti_pkg and rti_div.
// Between the accepting edge and the edge that raises done lie six arithmetic stages,
//   one divider stage per distance bit and one output stage.
// Throughput: one request per cycle; busy stays low, results cannot be held off.
// Reset: clears the vertex registers to zero and drops every request in flight.
module ray_triangle_intersect
    import rti_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [COORD_WIDTH-1:0] origin_x,
    input  logic signed [COORD_WIDTH-1:0] origin_y,
    input  logic signed [COORD_WIDTH-1:0] origin_z,
    input  logic signed [COORD_WIDTH-1:0] dir_x,
    input  logic signed [COORD_WIDTH-1:0] dir_y,
    input  logic signed [COORD_WIDTH-1:0] dir_z,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]       cfg_data,
    output logic                       done,
    output logic                       hit,
    output logic [DIST_WIDTH-1:0]      distance
);

    // ------------------------------------------------------------------
    // Vertex registers: user must write only while no request is in flight (unenforced).
    // ------------------------------------------------------------------
    logic [CFG_WIDTH-1:0] vertex_reg [NUM_VERTEX];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_VERTEX; i++)
            begin
                vertex_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VERTEX_A: vertex_reg[0] <= cfg_data;
                REG_VERTEX_B: vertex_reg[1] <= cfg_data;
                REG_VERTEX_C: vertex_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // The pipeline never stalls, so a request is taken whenever start is high.
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: edge vectors and vertex-minus-origin vectors.
    // p[i] = v[i] - o; p[0] doubles as w for the plane distance.
    // ------------------------------------------------------------------
    coord_t vtx [NUM_VERTEX][3];
    coord_t org [3];
    coord_t dir [3];
    diff_t  p_next  [NUM_VERTEX][3];
    diff_t  e0_next [3];
    diff_t  e1_next [3];
    diff_t  d_next  [3];

    assign org[0] = origin_x;
    assign org[1] = origin_y;
    assign org[2] = origin_z;
    assign dir[0] = dir_x;
    assign dir[1] = dir_y;
    assign dir[2] = dir_z;

    always_comb
    begin
        for (int i = 0; i < NUM_VERTEX; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                vtx[i][k]    = coord_t'(vertex_reg[i][k*COORD_WIDTH +: COORD_WIDTH]);
                p_next[i][k] = diff_t'(vtx[i][k]) - diff_t'(org[k]);
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            e0_next[k] = diff_t'(vtx[1][k]) - diff_t'(vtx[0][k]);
            e1_next[k] = diff_t'(vtx[2][k]) - diff_t'(vtx[0][k]);
            d_next[k]  = diff_t'(dir[k]);
        end
    end

    logic  s1_valid_reg;
    diff_t p1_reg  [NUM_VERTEX][3];
    diff_t e0_reg  [3];
    diff_t e1_reg  [3];
    diff_t d1_reg  [3];

    // ------------------------------------------------------------------
    // Stage 2: the two partial products of every cross-product component.
    // Cross 0 is the normal (e1 x e0); cross 1..3 are the edge determinants
    // p[i] x p[i+1].
    // ------------------------------------------------------------------
    diff_t ca [NUM_CROSS][3];
    diff_t cb [NUM_CROSS][3];
    prod_t pa_next [NUM_CROSS][3];
    prod_t pb_next [NUM_CROSS][3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ca[0][k] = e1_reg[k];
            cb[0][k] = e0_reg[k];
        end
        for (int i = 0; i < NUM_VERTEX; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ca[i+1][k] = p1_reg[i][k];
                cb[i+1][k] = p1_reg[NEXT_IDX[i]][k];
            end
        end
        for (int c = 0; c < NUM_CROSS; c++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pa_next[c][k] = ca[c][NEXT_IDX[k]] * cb[c][PREV_IDX[k]];
                pb_next[c][k] = ca[c][PREV_IDX[k]] * cb[c][NEXT_IDX[k]];
            end
        end
    end

    logic  s2_valid_reg;
    prod_t pa_reg [NUM_CROSS][3];
    prod_t pb_reg [NUM_CROSS][3];
    diff_t w2_reg [3];
    diff_t d2_reg [3];

    // ------------------------------------------------------------------
    // Stage 3: finish the cross products.
    // ------------------------------------------------------------------
    cross_t cr_next [NUM_CROSS][3];

    always_comb
    begin
        for (int c = 0; c < NUM_CROSS; c++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                cr_next[c][k] = cross_t'(pa_reg[c][k]) - cross_t'(pb_reg[c][k]);
            end
        end
    end

    logic   s3_valid_reg;
    cross_t cr_reg [NUM_CROSS][3];
    diff_t  w3_reg [3];
    diff_t  d3_reg [3];

    // ------------------------------------------------------------------
    // Stage 4: dot-product terms. nv = n.d, xp = w.n, edge_i = c_i.d
    // ------------------------------------------------------------------
    dotp_t dp_next [NUM_DOT][3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dp_next[DOT_NV][k] = cr_reg[0][k] * d3_reg[k];
            dp_next[DOT_XP][k] = cr_reg[0][k] * w3_reg[k];
            for (int i = 0; i < NUM_VERTEX; i++)
            begin
                dp_next[DOT_EDGE+i][k] = cr_reg[i+1][k] * d3_reg[k];
            end
        end
    end

    logic  s4_valid_reg;
    dotp_t dp_reg [NUM_DOT][3];

    // ------------------------------------------------------------------
    // Stage 5: sum the dot-product terms.
    // ------------------------------------------------------------------
    sum_t sum_next [NUM_DOT];

    always_comb
    begin
        for (int j = 0; j < NUM_DOT; j++)
        begin
            sum_next[j] = sum_t'(dp_reg[j][0]) + sum_t'(dp_reg[j][1]) + sum_t'(dp_reg[j][2]);
        end
    end

    logic s5_valid_reg;
    sum_t sum_reg [NUM_DOT];

    // ------------------------------------------------------------------
    // Stage 6: hit decision, saturation check and divider set-up.
    // A hit needs nv > 0, xp > 0 and a negative determinant on every edge.
    // The quotient saturates when xp >= nv * 2^DIST_FRAC; otherwise it fits
    // in DIST_WIDTH bits, so the divider starts from xp >> (DIST_WIDTH-DIST_FRAC).
    // ------------------------------------------------------------------
    logic [SUM_WIDTH-1:0]  nv_u;
    logic [SUM_WIDTH-1:0]  xp_u;
    logic                  edges_in;
    div_ctrl_t             ctrl6_next;
    logic [REM_WIDTH-1:0]  rem6_next;
    logic [DIST_WIDTH-1:0] num6_next;

    assign nv_u = sum_reg[DOT_NV];
    assign xp_u = sum_reg[DOT_XP];

    always_comb
    begin
        edges_in = 1'b1;
        for (int i = 0; i < NUM_VERTEX; i++)
        begin
            edges_in = edges_in & sum_reg[DOT_EDGE+i][SUM_WIDTH-1];
        end
        ctrl6_next.valid = s5_valid_reg;
        ctrl6_next.pass  = !nv_u[SUM_WIDTH-1] && (|nv_u)
                         && !xp_u[SUM_WIDTH-1] && (|xp_u) && edges_in;
        ctrl6_next.sat   = {{DIST_FRAC{1'b0}}, xp_u} >= {nv_u, {DIST_FRAC{1'b0}}};
        rem6_next        = {1'b0, xp_u >> (DIST_WIDTH - DIST_FRAC)};
        num6_next        = {xp_u[DIST_WIDTH-DIST_FRAC-1:0], {DIST_FRAC{1'b0}}};
    end

    div_ctrl_t             ctrl6_reg;
    logic [SUM_WIDTH-1:0]  nv6_reg;
    logic [REM_WIDTH-1:0]  rem6_reg;
    logic [DIST_WIDTH-1:0] num6_reg;

    // ------------------------------------------------------------------
    // Valid bits travel with the data; advance every cycle.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            ctrl6_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            ctrl6_reg    <= ctrl6_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg   <= p_next;
        e0_reg   <= e0_next;
        e1_reg   <= e1_next;
        d1_reg   <= d_next;
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
        w2_reg   <= p1_reg[0];
        d2_reg   <= d1_reg;
        cr_reg   <= cr_next;
        w3_reg   <= w2_reg;
        d3_reg   <= d2_reg;
        dp_reg   <= dp_next;
        sum_reg  <= sum_next;
        nv6_reg  <= nv_u;
        rem6_reg <= rem6_next;
        num6_reg <= num6_next;
    end

    // ------------------------------------------------------------------
    // Divider: t = (xp << DIST_FRAC) / nv, truncated.
    // ------------------------------------------------------------------
    div_ctrl_t             div_ctrl;
    logic [DIST_WIDTH-1:0] div_quot;

    rti_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_in  (ctrl6_reg),
        .den_in   (nv6_reg),
        .rem_in   (rem6_reg),
        .num_in   (num6_reg),
        .ctrl_out (div_ctrl),
        .quot_out (div_quot)
    );

    // ------------------------------------------------------------------
    // Output register: a miss or a saturated hit reports all ones.
    // ------------------------------------------------------------------
    logic                  done_reg;
    logic                  hit_reg;
    logic [DIST_WIDTH-1:0] distance_reg;
    logic [DIST_WIDTH-1:0] distance_next;

    assign distance_next = (!div_ctrl.pass || div_ctrl.sat) ? {DIST_WIDTH{1'b1}} : div_quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg      <= div_ctrl.pass;
        distance_reg <= distance_next;
    end

    assign done     = done_reg;
    assign hit      = hit_reg;
    assign distance = distance_reg;

endmodule

@@ rtl/core/rti_checker.sv @@
// Port-level checker for ray_triangle_intersect, bound to the top level.
// Depends on rti_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rti_checker
    import rti_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  done,
    input logic                  hit,
    input logic [DIST_WIDTH-1:0] distance
);

    // the pipeline takes a request every cycle
    `ASSERT_ALWAYS(busy_low_a, !busy)

    // a miss reports all ones
    `ASSERT_IMPLY(miss_distance_a, done && !hit, distance == {DIST_WIDTH{1'b1}})

    // every result traces back to a request a fixed latency earlier
    `ASSERT_IMPLY(done_has_request_a, done, $past(start, LATENCY))

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (.*);

@@ dv/ray_triangle_intersect_test.sv @@
// Self-checking testbench for ray_triangle_intersect: directed and random rays against
// several triangles, each result checked against an exact integer intersection predictor.
// Depends on rti_pkg and the ray_triangle_intersect RTL.
`timescale 1ns / 1ps

module ray_triangle_intersect_test;
    import rti_pkg::*;

    typedef logic signed [127:0] big_t;
    typedef enum logic [1:0] {OP_RAY, OP_WRITE, OP_DRAIN} op_t;

    typedef struct {
        op_t                  op;
        coord_t               ox, oy, oz, dx, dy, dz;
        logic [CFG_INDEX_WIDTH-1:0] idx;
        logic [CFG_WIDTH-1:0] data;
        int unsigned          gap;
    } request_t;

    typedef struct {
        logic                  hit;
        logic [DIST_WIDTH-1:0] distance;
    } answer_t;

    localparam int SETTLE_CYCLES = LATENCY + 4;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [DIST_WIDTH-1:0] DIST_ALL_ONES = '1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    coord_t origin_x = '0, origin_y = '0, origin_z = '0;
    coord_t dir_x = '0, dir_y = '0, dir_z = '0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_VERTEX_A;
    logic [CFG_WIDTH-1:0] cfg_data = '0;
    logic done, hit;
    logic [DIST_WIDTH-1:0] distance;

    request_t pending_requests[$];
    answer_t  expected_answers[$];
    logic [CFG_WIDTH-1:0] vertex_regs[3] = '{default: '0};
    int unsigned mismatches = 0;
    int unsigned rays_checked = 0;
    int unsigned hits_seen = 0;
    int unsigned saturated_seen = 0;
    int unsigned settle_count = 0;
    int unsigned quiet_cycles = 0;

    ray_triangle_intersect uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .hit(hit), .distance(distance)
    );

    always #5 clk = ~clk;

    // One component of a x b: a1*b2 - a2*b1 on the two other axes
    function automatic big_t cross_part(big_t a1, big_t a2, big_t b1, big_t b2);
        return a1 * b2 - a2 * b1;
    endfunction

    // Exact intersection: unnormalised normal, signed volumes for the edges,
    // one truncating division for the distance.
    function automatic answer_t predict_intersection(request_t r);
        big_t v[3][3], o[3], d[3], e0[3], e1[3], n[3], p[3], q[3], c[3];
        big_t nv, xp, vol;
        logic [127:0] quo;
        answer_t ans;
        ans.hit = 1'b0;
        ans.distance = DIST_ALL_ONES;
        o = '{big_t'(r.ox), big_t'(r.oy), big_t'(r.oz)};
        d = '{big_t'(r.dx), big_t'(r.dy), big_t'(r.dz)};
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                v[i][k] = big_t'($signed(vertex_regs[i][k*COORD_WIDTH +: COORD_WIDTH]));
        for (int k = 0; k < 3; k++)
        begin
            e0[k] = v[1][k] - v[0][k];
            e1[k] = v[2][k] - v[0][k];
        end
        for (int k = 0; k < 3; k++)
            n[k] = cross_part(e1[NEXT_IDX[k]], e1[PREV_IDX[k]], e0[NEXT_IDX[k]], e0[PREV_IDX[k]]);
        nv = n[0] * d[0] + n[1] * d[1] + n[2] * d[2];
        if (nv <= 0)
            return ans;
        xp = (v[0][0] - o[0]) * n[0] + (v[0][1] - o[1]) * n[1] + (v[0][2] - o[2]) * n[2];
        if (xp <= 0)
            return ans;
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p[k] = v[i][k] - o[k];
                q[k] = v[NEXT_IDX[i]][k] - o[k];
            end
            for (int k = 0; k < 3; k++)
                c[k] = cross_part(p[NEXT_IDX[k]], p[PREV_IDX[k]], q[NEXT_IDX[k]], q[PREV_IDX[k]]);
            vol = c[0] * d[0] + c[1] * d[1] + c[2] * d[2];
            if (vol >= 0)
                return ans;
        end
        quo = (128'(xp) << DIST_FRAC) / 128'(nv);
        ans.hit = 1'b1;
        ans.distance = (quo >= 128'(DIST_ALL_ONES)) ? DIST_ALL_ONES : quo[DIST_WIDTH-1:0];
        return ans;
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // Driver: hold a request until accepted, then advance through the queue.
    always @(posedge clk)
    begin
        logic nx_start, nx_we;
        request_t head;
        nx_start = 1'b0;
        nx_we = 1'b0;
        if (!rst_n)
        begin
            start <= 1'b0;
            cfg_we <= 1'b0;
        end
        else if (start && busy)
        begin
            start <= 1'b1;
            cfg_we <= 1'b0;
        end
        else
        begin
            if (pending_requests.size() > 0)
            begin
                head = pending_requests[0];
                case (head.op)
                    OP_DRAIN:
                    begin
                        // hold until every outstanding request has answered and settled
                        if (expected_answers.size() == 0 && !start)
                            settle_count++;
                        else
                            settle_count = 0;
                        if (settle_count >= SETTLE_CYCLES)
                        begin
                            settle_count = 0;
                            void'(pending_requests.pop_front());
                        end
                    end
                    OP_WRITE:
                    begin
                        void'(pending_requests.pop_front());
                        nx_we = 1'b1;
                        cfg_index <= head.idx;
                        cfg_data <= head.data;
                    end
                    default:
                    begin
                        if ($urandom_range(99) >= head.gap)
                        begin
                            void'(pending_requests.pop_front());
                            nx_start = 1'b1;
                            origin_x <= head.ox;
                            origin_y <= head.oy;
                            origin_z <= head.oz;
                            dir_x <= head.dx;
                            dir_y <= head.dy;
                            dir_z <= head.dz;
                        end
                    end
                endcase
            end
            start <= nx_start;
            cfg_we <= nx_we;
        end
    end

    // Monitor: track register writes, predict on acceptance, check each done strobe.
    always @(posedge clk)
    begin
        request_t acc;
        answer_t want;
        if (rst_n)
        begin
            quiet_cycles++;
            if (cfg_we)
                vertex_regs[cfg_index] = cfg_data;
            if (start && !busy)
            begin
                acc.ox = origin_x; acc.oy = origin_y; acc.oz = origin_z;
                acc.dx = dir_x; acc.dy = dir_y; acc.dz = dir_z;
                expected_answers.push_back(predict_intersection(acc));
                quiet_cycles = 0;
            end
            if (done)
            begin
                quiet_cycles = 0;
                if (expected_answers.size() == 0)
                    report_mismatch("result with no request outstanding");
                else
                begin
                    want = expected_answers.pop_front();
                    rays_checked++;
                    if (want.hit)
                        hits_seen++;
                    if (want.hit && want.distance == DIST_ALL_ONES)
                        saturated_seen++;
                    if (hit !== want.hit)
                        report_mismatch($sformatf("hit %b, want %b", hit, want.hit));
                    if (distance !== want.distance)
                        report_mismatch($sformatf("distance %h, want %h",
                                                  distance, want.distance));
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no request or result for %0d cycles", quiet_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic logic [CFG_WIDTH-1:0] pack_vertex(int x, int y, int z);
        return {coord_t'(z), coord_t'(y), coord_t'(x)};
    endfunction

    function automatic request_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                          int unsigned gap);
        request_t r;
        r.op = OP_RAY;
        r.ox = coord_t'(ox); r.oy = coord_t'(oy); r.oz = coord_t'(oz);
        r.dx = coord_t'(dx); r.dy = coord_t'(dy); r.dz = coord_t'(dz);
        r.gap = gap;
        return r;
    endfunction

    // Drain, then rewrite all three vertices, cyclically from a random first one.
    task automatic queue_triangle(logic [CFG_WIDTH-1:0] a, logic [CFG_WIDTH-1:0] b,
                                  logic [CFG_WIDTH-1:0] c);
        request_t r;
        logic [CFG_WIDTH-1:0] vals[3];
        int first;
        vals = '{a, b, c};
        first = $urandom_range(2);
        r.op = OP_DRAIN;
        pending_requests.push_back(r);
        for (int i = 0; i < 3; i++)
        begin
            r.op = OP_WRITE;
            r.idx = CFG_INDEX_WIDTH'((first + i) % 3);
            r.data = vals[(first + i) % 3];
            pending_requests.push_back(r);
        end
    endtask

    function automatic int rnd_coord(int span);
        return $urandom_range(2 * span) - span;
    endfunction

    initial
    begin
        int vx[3][3];
        int gaps[4] = '{0, 67, 6, 67};
        int w1, w2, w3, sh, kind, ox, oy, oz, tgt;
        int o[3];
        int dv[3];
        logic [CFG_WIDTH-1:0] vr[3];
        request_t r;

        // Directed: degenerate triangle straight after reset
        pending_requests.push_back(make_ray(1000, 1000, 4096, 0, 0, -4096, 0));
        pending_requests.push_back(make_ray(-524288, -524288, -524288, 524287, 524287, 524287, 0));
        // unit right triangle in the z = 0 plane, front face towards +z
        queue_triangle(pack_vertex(0, 0, 0), pack_vertex(4096, 0, 0), pack_vertex(0, 4096, 0));
        pending_requests.push_back(make_ray(1000, 1000, 4096, 0, 0, -4096, 0));    // plain hit
        pending_requests.push_back(make_ray(1000, 1000, -4096, 0, 0, 4096, 0));    // back face
        pending_requests.push_back(make_ray(1000, 1000, 4096, 4096, 0, 0, 0));     // parallel
        pending_requests.push_back(make_ray(1000, 1000, -4096, 0, 0, -4096, 0));   // behind origin
        pending_requests.push_back(make_ray(5000, 1000, 4096, 0, 0, -4096, 0));    // outside
        pending_requests.push_back(make_ray(0, 1000, 4096, 0, 0, -4096, 0));       // on an edge
        pending_requests.push_back(make_ray(0, 0, 4096, 0, 0, -4096, 0));          // on a vertex
        pending_requests.push_back(make_ray(100, 100, 524287, 0, 0, -1, 0));       // saturates
        pending_requests.push_back(make_ray(100, 100, 1, 0, 0, -524288, 0));       // t truncates to 0
        pending_requests.push_back(make_ray(100, 100, 4096, 0, 0, 0, 0));          // zero direction
        pending_requests.push_back(make_ray(524287, 524287, 524287, -524288, -524288, -524288, 0));
        pending_requests.push_back(make_ray(-524288, -524288, 524287, 524287, 524287, -524288, 0));
        pending_requests.push_back(make_ray(1, 1, 524287, 0, 0, -524288, 0));
        pending_requests.push_back(make_ray(2000, 2000, 8192, 100, -50, -4096, 0));

        // Random phases: each picks a triangle, a sender gap rate and about 150 rays
        for (int ph = 0; ph < 10; ph++)
        begin
            kind = (ph % 2 == 0) ? 0 : (ph / 2) % 5;
            for (int i = 0; i < 3; i++)
            begin
                for (int k = 0; k < 3; k++)
                    vx[i][k] = rnd_coord(65536);
                case (kind)
                    1: vr[i] = CFG_WIDTH'({$urandom, $urandom});
                    2: vr[i] = '1;
                    3: vr[i] = pack_vertex(524287, 524287, 524287) ^ (CFG_WIDTH'(1) << i);
                    4: vr[i] = pack_vertex(-524288, -524288, -524288) | (CFG_WIDTH'(1) << (20*i));
                    default: vr[i] = pack_vertex(vx[i][0], vx[i][1], vx[i][2]);
                endcase
            end
            queue_triangle(vr[0], vr[1], vr[2]);
            for (int n = 0; n < 153; n++)
            begin
                if (kind == 0 && $urandom_range(99) < 75)
                begin
                    // aim through a weighted interior point, from either side
                    w1 = $urandom_range(1, 6);
                    w2 = $urandom_range(1, 7 - w1);
                    w3 = 8 - w1 - w2;
                    sh = ($urandom_range(3) == 0) ? $urandom_range(6) : 0;
                    for (int k = 0; k < 3; k++)
                    begin
                        o[k] = rnd_coord(131072);
                        tgt = (w1 * vx[0][k] + w2 * vx[1][k] + w3 * vx[2][k]) / 8;
                        dv[k] = (tgt - o[k]) >>> sh;
                    end
                    r = make_ray(o[0], o[1], o[2], dv[0], dv[1], dv[2], gaps[ph % 4]);
                end
                else
                begin
                    r = make_ray(rnd_coord(524288) < 524288 ? rnd_coord(524288) : 0,
                                 $urandom, $urandom, $urandom, $urandom, $urandom,
                                 gaps[ph % 4]);
                    r.ox = coord_t'($urandom);
                end
                pending_requests.push_back(r);
            end
            // also let the pipeline empty once more after the fourth phase's rays
            if (ph == 3)
            begin
                r.op = OP_DRAIN;
                pending_requests.push_back(r);
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_requests.size() == 0 && expected_answers.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d rays over 12 triangle settings: %0d hits, %0d saturated.",
                 rays_checked, hits_seen, saturated_seen);
        if (mismatches == 0 && expected_answers.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/rti_pkg.sv
rtl/core/rti_div.sv
rtl/core/ray_triangle_intersect.sv
rtl/core/rti_checker.sv
dv/ray_triangle_intersect_test.sv
